>>> rtl/nps_pkg.sv
// Package for the nearest point search unit: widths, command codes,
// sequencer states and the packed table entry. No dependencies.
package nps_pkg;

    localparam int unsigned MAX_POINTS_DEF = 1024;

    localparam int unsigned ID_W    = 12;
    localparam int unsigned COORD_W = 16;
    localparam int unsigned SLOT_W  = 10;
    localparam int unsigned CFG_W   = 11;
    localparam int unsigned DIFF_W  = COORD_W + 1;
    localparam int unsigned DIST_W  = 33;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN
    } state_t;

    typedef struct packed {
        logic        [ID_W-1:0]    id;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } point_t;

    localparam int unsigned POINT_W = $bits(point_t);

endpackage

>>> rtl/nps_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module nps_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/nearest_point_search_unit.sv
// Nearest point search: a query scans the first n table slots, n = min(points_in_use,
// MAX_POINTS), and ends with the done strobe; an empty table answers with found low.
// A load is written while idle and busy stays low. Busy is high for a whole query, so
// no new command is taken until that query is through; the table RAM has one read port.
// Results are strobed for one cycle on done; the receiver cannot stall.
// Reset (rst_n, async, active low) clears control and points_in_use; table undefined.
// Depends on nps_pkg and nps_ram.
module nearest_point_search_unit #(
    parameter int unsigned MAX_POINTS = nps_pkg::MAX_POINTS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // command channel
    input  logic                                start,
    output logic                                busy,
    input  logic                                cmd,
    input  logic [nps_pkg::SLOT_W-1:0]          slot,
    input  logic [nps_pkg::ID_W-1:0]            point_id,
    input  logic signed [nps_pkg::COORD_W-1:0]  pos_x,
    input  logic signed [nps_pkg::COORD_W-1:0]  pos_y,
    // configuration
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [nps_pkg::CFG_W-1:0]           cfg_data,
    // result
    output logic                                done,
    output logic                                found,
    output logic [nps_pkg::ID_W-1:0]            best_id,
    output logic signed [nps_pkg::COORD_W-1:0]  best_x,
    output logic signed [nps_pkg::COORD_W-1:0]  best_y,
    output logic [nps_pkg::DIST_W-1:0]          best_dist_sq
);

    localparam int unsigned AW      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int unsigned CNT_RAW = $clog2(MAX_POINTS + 1);
    localparam int unsigned CNT_W   = (CNT_RAW > nps_pkg::CFG_W) ? CNT_RAW : nps_pkg::CFG_W;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_POINTS);

    nps_pkg::state_t state_reg, state_next;

    logic [nps_pkg::CFG_W-1:0]          points_in_use_reg;
    logic [CNT_W-1:0]                   idx_reg, idx_next;
    logic [CNT_W-1:0]                   n_reg;
    logic [CNT_W-1:0]                   n_eff;
    logic [CNT_W-1:0]                   slot_ext;
    logic signed [nps_pkg::COORD_W-1:0] qx_reg, qy_reg;

    logic rd_valid_reg, sq_valid_reg;
    logic found_reg, done_reg, done_next;
    logic query_start, load_we, issue;

    nps_pkg::point_t ram_wdata, ram_rdata, cand_reg;

    logic signed [nps_pkg::DIFF_W-1:0]   dx, dy;
    logic signed [2*nps_pkg::DIFF_W-1:0] dx2, dy2;
    logic [nps_pkg::DIST_W-1:0]          sq_x_reg, sq_y_reg;
    logic [nps_pkg::DIST_W-1:0]          dist_sum;
    logic                                take;

    nps_pkg::point_t            best_reg;
    logic [nps_pkg::DIST_W-1:0] best_dist_reg;

    function automatic logic signed [nps_pkg::DIFF_W-1:0] DIFF_W_ext(
        input logic signed [nps_pkg::COORD_W-1:0] v
    );
        return nps_pkg::DIFF_W'(v);
    endfunction

    // ------------------------------------------------------------------
    // table RAM
    // ------------------------------------------------------------------
    assign ram_wdata = '{id: point_id, x: pos_x, y: pos_y};

    nps_ram #(
        .WIDTH (nps_pkg::POINT_W),
        .DEPTH (MAX_POINTS)
    ) u_table (
        .clk   (clk),
        .we    (load_we),
        .waddr (slot_ext[AW-1:0]),
        .wdata (ram_wdata),
        .re    (issue),
        .raddr (idx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    assign slot_ext = CNT_W'(slot);
    assign n_eff    = (CNT_W'(points_in_use_reg) > MAX_CNT) ? MAX_CNT
                                                            : CNT_W'(points_in_use_reg);

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        issue       = 1'b0;
        query_start = 1'b0;
        load_we     = 1'b0;
        done_next   = 1'b0;
        unique case (state_reg)
            nps_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    if (cmd == nps_pkg::CMD_QUERY)
                    begin
                        query_start = 1'b1;
                        idx_next    = '0;
                        state_next  = (n_eff == '0) ? nps_pkg::ST_DRAIN : nps_pkg::ST_SCAN;
                    end
                    else
                    begin
                        load_we = (slot_ext < MAX_CNT);
                    end
                end
            end
            nps_pkg::ST_SCAN:
            begin
                issue    = 1'b1;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == n_reg - 1'b1)
                begin
                    state_next = nps_pkg::ST_DRAIN;
                end
            end
            nps_pkg::ST_DRAIN:
            begin
                if (!rd_valid_reg && !sq_valid_reg)
                begin
                    done_next  = 1'b1;
                    state_next = nps_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = nps_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= nps_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------
    // shared distance datapath: difference and square, then add and compare
    // ------------------------------------------------------------------
    assign dx  = DIFF_W_ext(ram_rdata.x) - DIFF_W_ext(qx_reg);
    assign dy  = DIFF_W_ext(ram_rdata.y) - DIFF_W_ext(qy_reg);
    assign dx2 = dx * dx;
    assign dy2 = dy * dy;

    // squares never exceed 2^32, and their sum stays below 2^33
    assign dist_sum = sq_x_reg + sq_y_reg;
    assign take     = sq_valid_reg && (!found_reg || (dist_sum < best_dist_reg));

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            points_in_use_reg <= '0;
            idx_reg           <= '0;
            rd_valid_reg      <= 1'b0;
            sq_valid_reg      <= 1'b0;
            found_reg         <= 1'b0;
            done_reg          <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                points_in_use_reg <= cfg_data;
            end
            idx_reg      <= idx_next;
            rd_valid_reg <= issue;
            sq_valid_reg <= rd_valid_reg;
            done_reg     <= done_next;
            if (query_start)
            begin
                found_reg <= 1'b0;
            end
            else if (take)
            begin
                found_reg <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (query_start)
        begin
            n_reg         <= n_eff;
            qx_reg        <= pos_x;
            qy_reg        <= pos_y;
            best_reg      <= '0;
            best_dist_reg <= '0;
        end
        else if (take)
        begin
            best_reg      <= cand_reg;
            best_dist_reg <= dist_sum;
        end
        if (rd_valid_reg)
        begin
            sq_x_reg <= dx2[nps_pkg::DIST_W-1:0];
            sq_y_reg <= dy2[nps_pkg::DIST_W-1:0];
            cand_reg <= ram_rdata;
        end
    end

    // ------------------------------------------------------------------
    // outputs
    // ------------------------------------------------------------------
    assign busy         = (state_reg != nps_pkg::ST_IDLE);
    assign cfg_ready    = 1'b1;
    assign done         = done_reg;
    assign found        = found_reg;
    assign best_id      = best_reg.id;
    assign best_x       = best_reg.x;
    assign best_y       = best_reg.y;
    assign best_dist_sq = best_dist_reg;

`ifndef SYNTHESIS
    // pipeline must be empty whenever a new transaction can be taken
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> (!rd_valid_reg && !sq_valid_reg))
        else $error("distance pipeline not empty while idle");

    // one strobe per query
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobed on consecutive cycles");

    // empty search returns all-zero fields
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !found) |-> (best_dist_sq == '0 && best_id == '0))
        else $error("empty search returned non-zero result");

    // RAM reads are only issued while scanning
    a_read_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> $past(state_reg == nps_pkg::ST_SCAN))
        else $error("table read outside scan");
`endif

endmodule

>>> sim/nps_checker.sv
// Checker for the nearest point search unit: watches the command, configuration
// and result channels, keeps its own point table and predicts every query answer.
// Depends on nps_pkg.
module nps_checker #(
    parameter int unsigned MAX_POINTS = nps_pkg::MAX_POINTS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  logic                                cmd,
    input  logic [nps_pkg::SLOT_W-1:0]          slot,
    input  logic [nps_pkg::ID_W-1:0]            point_id,
    input  logic signed [nps_pkg::COORD_W-1:0]  pos_x,
    input  logic signed [nps_pkg::COORD_W-1:0]  pos_y,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [nps_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                done,
    input  logic                                found,
    input  logic [nps_pkg::ID_W-1:0]            best_id,
    input  logic signed [nps_pkg::COORD_W-1:0]  best_x,
    input  logic signed [nps_pkg::COORD_W-1:0]  best_y,
    input  logic [nps_pkg::DIST_W-1:0]          best_dist_sq,
    output int unsigned                         fail_count,
    output int unsigned                         pending
);

    typedef struct packed {
        logic                               found;
        logic        [nps_pkg::ID_W-1:0]    id;
        logic signed [nps_pkg::COORD_W-1:0] x;
        logic signed [nps_pkg::COORD_W-1:0] y;
        logic        [nps_pkg::DIST_W-1:0]  dist_sq;
    } nearest_t;

    nps_pkg::point_t           point_table [MAX_POINTS];
    logic [nps_pkg::CFG_W-1:0] search_len;
    nearest_t                  answers_due [$];
    nearest_t                  want;
    nearest_t                  got;

    function automatic nearest_t nearest_in_table(
        input logic signed [nps_pkg::COORD_W-1:0] qx,
        input logic signed [nps_pkg::COORD_W-1:0] qy
    );
        nearest_t                          r;
        int unsigned                       n;
        int unsigned                       i;
        logic signed [nps_pkg::DIFF_W-1:0] dx;
        logic signed [nps_pkg::DIFF_W-1:0] dy;
        logic [nps_pkg::DIST_W-1:0]        d;
        r = '0;
        n = (search_len > MAX_POINTS) ? MAX_POINTS : search_len;
        for (i = 0; i < n; i++)
        begin
            dx = point_table[i].x - qx;
            dy = point_table[i].y - qy;
            d  = dx * dx + dy * dy;
            // strict compare: the lower slot keeps a tie
            if (!r.found || d < r.dist_sq)
            begin
                r.found   = 1'b1;
                r.id      = point_table[i].id;
                r.x       = point_table[i].x;
                r.y       = point_table[i].y;
                r.dist_sq = d;
            end
        end
        return r;
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            search_len = '0;
            answers_due.delete();
            fail_count = 0;
        end
        else
        begin
            // retire the answer first: a new query may be accepted at the same edge
            if (done)
            begin
                got.found   = found;
                got.id      = best_id;
                got.x       = best_x;
                got.y       = best_y;
                got.dist_sq = best_dist_sq;
                if (answers_due.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: answer with no query outstanding: found=%0d id=%0d",
                                 $time, found, best_id);
                end
                else
                begin
                    want = answers_due.pop_front();
                    if (got !== want)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                        begin
                            $display("%0t: nearest point mismatch", $time);
                            $display("  expected found=%0d id=%0d x=%0d y=%0d dist_sq=%0d",
                                     want.found, want.id, want.x, want.y, want.dist_sq);
                            $display("  actual   found=%0d id=%0d x=%0d y=%0d dist_sq=%0d",
                                     got.found, got.id, got.x, got.y, got.dist_sq);
                        end
                    end
                end
            end
            if (start && !busy)
            begin
                if (cmd == nps_pkg::CMD_LOAD)
                begin
                    if (slot < MAX_POINTS)
                    begin
                        point_table[slot].id = point_id;
                        point_table[slot].x  = pos_x;
                        point_table[slot].y  = pos_y;
                    end
                end
                else
                    answers_due = {answers_due, nearest_in_table(pos_x, pos_y)};
            end
            if (cfg_valid && cfg_ready)
                search_len = cfg_data;
        end
        pending = answers_due.size();
    end

endmodule

>>> sim/tb_nearest_point_search_unit.sv
// Testbench top for the nearest point search unit: clock, reset, load and query
// stimulus and the verdict. Depends on nps_pkg, nearest_point_search_unit and nps_checker.
module tb_nearest_point_search_unit;

    localparam int unsigned TABLE_DEPTH = nps_pkg::MAX_POINTS_DEF;

    logic                               clk;
    logic                               rst_n;
    logic                               start;
    logic                               busy;
    logic                               cmd;
    logic [nps_pkg::SLOT_W-1:0]         slot;
    logic [nps_pkg::ID_W-1:0]           point_id;
    logic signed [nps_pkg::COORD_W-1:0] pos_x;
    logic signed [nps_pkg::COORD_W-1:0] pos_y;
    logic                               cfg_valid;
    logic                               cfg_ready;
    logic [nps_pkg::CFG_W-1:0]          cfg_data;
    logic                               done;
    logic                               found;
    logic [nps_pkg::ID_W-1:0]           best_id;
    logic signed [nps_pkg::COORD_W-1:0] best_x;
    logic signed [nps_pkg::COORD_W-1:0] best_y;
    logic [nps_pkg::DIST_W-1:0]         best_dist_sq;
    int unsigned                        fail_count;
    int unsigned                        pending;

    // what has been loaded so far, so queries only ever search written slots
    bit                                 written  [TABLE_DEPTH];
    bit signed [nps_pkg::COORD_W-1:0]   shadow_x [TABLE_DEPTH];
    bit signed [nps_pkg::COORD_W-1:0]   shadow_y [TABLE_DEPTH];
    int unsigned                        prefix;
    int unsigned                        active_points;
    int unsigned                        rand_items;
    bit                                 gaps_on;

    nearest_point_search_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .slot         (slot),
        .point_id     (point_id),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .done         (done),
        .found        (found),
        .best_id      (best_id),
        .best_x       (best_x),
        .best_y       (best_y),
        .best_dist_sq (best_dist_sq)
    );

    nps_checker #(
        .MAX_POINTS (TABLE_DEPTH)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .slot         (slot),
        .point_id     (point_id),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .done         (done),
        .found        (found),
        .best_id      (best_id),
        .best_x       (best_x),
        .best_y       (best_y),
        .best_dist_sq (best_dist_sq),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #(12 * 500000);
        $display("TB_ERROR");
        $finish;
    end

    function automatic logic signed [nps_pkg::COORD_W-1:0] clamp_coord(input int v);
        int c;
        c = v;
        if (c > 32767)
            c = 32767;
        if (c < -32768)
            c = -32768;
        return nps_pkg::COORD_W'(c);
    endfunction

    function automatic logic signed [nps_pkg::COORD_W-1:0] rand_coord();
        return nps_pkg::COORD_W'($urandom());
    endfunction

    // searched span as the block sees it, at least one slot
    function automatic int unsigned search_span();
        int unsigned s;
        s = (active_points > TABLE_DEPTH) ? TABLE_DEPTH : active_points;
        return (s == 0) ? 1 : s;
    endfunction

    // one command transaction; ends at the accepting edge with start still high
    task automatic send_item(input logic c, input logic [nps_pkg::SLOT_W-1:0] s,
                             input logic [nps_pkg::ID_W-1:0] id,
                             input logic signed [nps_pkg::COORD_W-1:0] x,
                             input logic signed [nps_pkg::COORD_W-1:0] y);
        int unsigned gap;
        @(negedge clk);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            start = 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(negedge clk);
        end
        start    = 1'b1;
        cmd      = c;
        slot     = s;
        point_id = id;
        pos_x    = x;
        pos_y    = y;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic load_point(input int unsigned s, input logic [nps_pkg::ID_W-1:0] id,
                              input logic signed [nps_pkg::COORD_W-1:0] x,
                              input logic signed [nps_pkg::COORD_W-1:0] y);
        send_item(nps_pkg::CMD_LOAD, nps_pkg::SLOT_W'(s), id, x, y);
        written[s]  = 1'b1;
        shadow_x[s] = x;
        shadow_y[s] = y;
        while (prefix < TABLE_DEPTH && written[prefix])
            prefix++;
    endtask

    task automatic query_at(input logic signed [nps_pkg::COORD_W-1:0] x,
                            input logic signed [nps_pkg::COORD_W-1:0] y);
        // slot and id are don't-care on a query, so toggle them anyway
        send_item(nps_pkg::CMD_QUERY, nps_pkg::SLOT_W'($urandom()),
                  nps_pkg::ID_W'($urandom()), x, y);
    endtask

    // drop start and hold off until every answer is in and the block is idle
    task automatic wait_quiet();
        int unsigned w;
        @(negedge clk);
        start = 1'b0;
        w = 0;
        while ((pending != 0 || busy) && w < 4000)
        begin
            @(negedge clk);
            w++;
        end
        repeat (4) @(negedge clk);
    endtask

    task automatic set_points(input int unsigned v);
        wait_quiet();
        cfg_valid = 1'b1;
        cfg_data  = nps_pkg::CFG_W'(v);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
        active_points = v;
    endtask

    task automatic random_load();
        int unsigned                        k;
        int unsigned                        s;
        int unsigned                        src;
        logic signed [nps_pkg::COORD_W-1:0] x;
        logic signed [nps_pkg::COORD_W-1:0] y;
        k = $urandom_range(0, 99);
        if (k < 60)
            s = $urandom_range(0, search_span() - 1);
        else if (k < 85)
            s = $urandom_range(0, (prefix < TABLE_DEPTH) ? prefix : TABLE_DEPTH - 1);
        else
            s = $urandom_range(0, TABLE_DEPTH - 1);
        k = $urandom_range(0, 99);
        if (k < 40 || prefix == 0)
        begin
            x = rand_coord();
            y = rand_coord();
        end
        else if (k < 70)
        begin
            // duplicate position: provokes equal distances
            src = $urandom_range(0, prefix - 1);
            x = shadow_x[src];
            y = shadow_y[src];
        end
        else
        begin
            x = clamp_coord(int'($urandom_range(0, 128)) - 64);
            y = clamp_coord(int'($urandom_range(0, 128)) - 64);
        end
        load_point(s, nps_pkg::ID_W'($urandom()), x, y);
    endtask

    task automatic random_query();
        int unsigned k;
        int unsigned src;
        k = $urandom_range(0, 99);
        if (k < 40 || active_points == 0)
            query_at(rand_coord(), rand_coord());
        else if (k < 80)
        begin
            src = $urandom_range(0, search_span() - 1);
            query_at(clamp_coord(int'(shadow_x[src]) + int'($urandom_range(0, 6)) - 3),
                     clamp_coord(int'(shadow_y[src]) + int'($urandom_range(0, 6)) - 3));
        end
        else
            query_at(clamp_coord(int'($urandom_range(0, 128)) - 64),
                     clamp_coord(int'($urandom_range(0, 128)) - 64));
    endtask

    task automatic run_phase();
        int unsigned k;
        int unsigned n;
        int unsigned len;
        if (rand_items >= 480)
            gaps_on = 1'b0;
        else
            gaps_on = ($urandom_range(0, 3) != 0);
        k = $urandom_range(0, 99);
        if (k < 5)
            n = 0;
        else if (k < 75)
            n = $urandom_range(1, 12);
        else if (k < 95)
            n = $urandom_range(13, 48);
        else
            n = $urandom_range(49, 96);
        while (prefix < n)
        begin
            load_point(prefix, nps_pkg::ID_W'($urandom()), rand_coord(), rand_coord());
            rand_items++;
        end
        set_points(n);
        len = $urandom_range(8, 24);
        repeat (len)
        begin
            if ($urandom_range(0, 99) < 35)
                random_load();
            else
                random_query();
            rand_items++;
            if ($urandom_range(0, 59) == 0)
                wait_quiet();
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        start         = 1'b0;
        cmd           = nps_pkg::CMD_LOAD;
        slot          = '0;
        point_id      = '0;
        pos_x         = '0;
        pos_y         = '0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        prefix        = 0;
        active_points = 0;
        rand_items    = 0;
        gaps_on       = 1'b1;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // empty table
        set_points(0);
        query_at(16'sd0, 16'sd0);
        query_at(-16'sd32768, 16'sd32767);

        // opposite corners, a symmetric pair and a coincident pair
        load_point(0, 12'd4095, -16'sd32768, -16'sd32768);
        load_point(1, 12'd0, 16'sd32767, 16'sd32767);
        load_point(2, 12'd7, 16'sd100, 16'sd0);
        load_point(3, 12'd8, -16'sd100, 16'sd0);
        load_point(4, 12'd2730, 16'sd0, 16'sd0);
        load_point(5, 12'd1365, 16'sd0, 16'sd0);

        set_points(1);
        query_at(16'sd32767, 16'sd32767);
        query_at(-16'sd32768, -16'sd32768);
        set_points(2);
        query_at(-16'sd32768, 16'sd32767);
        set_points(4);
        query_at(16'sd0, 16'sd0);
        query_at(-16'sd100, 16'sd0);
        set_points(6);
        query_at(16'sd0, 16'sd0);
        query_at(16'sd32767, 16'sd32767);
        query_at(16'sd32767, -16'sd32768);
        query_at(16'sd1, -16'sd1);
        wait_quiet();

        while (rand_items < 560)
            run_phase();

        wait_quiet();
        repeat (8) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> files.f
rtl/nps_pkg.sv
rtl/nps_ram.sv
rtl/nearest_point_search_unit.sv
sim/nps_checker.sv
sim/tb_nearest_point_search_unit.sv
